### rtl/lpt_greedy_group_balancer_core_assert.svh
// Assertion macros for the group balancer
`ifndef LPT_GREEDY_GROUP_BALANCER_CORE_ASSERT_SVH
`define LPT_GREEDY_GROUP_BALANCER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define LPT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpt_pkg.sv
// Shared types and constants for the group balancer
package lpt_pkg;
    localparam int MAX_JOBS   = 64;
    localparam int MAX_GROUPS = 16;
    localparam int JOB_W      = 6;
    localparam int CNT_W      = 7;
    localparam int GRP_W      = 4;
    localparam int SIZE_W     = 40;
    localparam int TOTAL_W    = 46;
    localparam int CFG_W      = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_ORD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_ASG_RD,
        ST_ASG_ID,
        ST_ASG_SCAN,
        ST_ASG_ADD
    } t_state;

    typedef struct packed {
        logic [JOB_W-1:0]   job_id;
        logic [GRP_W-1:0]   group_index;
        logic [TOTAL_W-1:0] group_total;
        logic               overflow;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic [SIZE_W-1:0] job_size;
        logic              is_last;
    } t_job;
endpackage

### rtl/lpt_stream_if.sv
// Valid/ready stream interfaces for jobs and results
interface lpt_job_if
    import lpt_pkg::*;
();
    logic valid;
    logic ready;
    t_job payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lpt_result_if
    import lpt_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/lpt_greedy_group_balancer_core.sv
// Top level: job load, stable sort and greedy group assignment
// Jobs load at one item per cycle while the input is ready, into a 64-entry
// size memory; items past 64 are dropped and set the overflow flag. The item
// marked last starts a run with the group count present at that item: group
// totals clear, then an insertion sort builds the job order through one shared
// 40-bit comparator. Each job in sorted order is then assigned to one of the
// groups in use (fetch id, scan one group per cycle, add into the smallest
// total); the add waits while the result register is not yet taken.
// The input is not ready from the last item until the final result of the
// run is loaded into the result register, which holds each result until taken.
`include "lpt_greedy_group_balancer_core_assert.svh"
module lpt_greedy_group_balancer_core
    import lpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    lpt_job_if.sink          i_job,
    lpt_result_if.source     o_res
);
    logic [SIZE_W-1:0]  size_mem [MAX_JOBS];
    logic [JOB_W-1:0]   order_mem [MAX_JOBS];
    logic [TOTAL_W-1:0] tot_mem [MAX_GROUPS];

    t_state r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_i, n_i;       // outer index
    logic [CNT_W-1:0]   r_j, n_j;       // insertion point
    logic [GRP_W:0]     r_k, n_k;       // group scan
    logic [GRP_W:0]     r_g;            // groups in use
    logic [GRP_W-1:0]   r_best, n_best;
    logic [TOTAL_W-1:0] r_bmin, n_bmin;
    logic [SIZE_W-1:0]  r_key;          // size being inserted
    logic [JOB_W-1:0]   r_id;           // job being assigned
    logic [SIZE_W-1:0]  r_sz_rd;
    logic [JOB_W-1:0]   r_ord_rd;
    logic [TOTAL_W-1:0] r_tot_rd;
    logic               r_ovalid;
    t_result            r_res;

    logic acc;
    assign acc = i_job.valid && i_job.ready;
    assign i_job.ready = (r_state == ST_LOAD);
    assign o_res.valid = r_ovalid;
    assign o_res.payload = r_res;

    // memory control
    logic               sz_we;
    logic [JOB_W-1:0]   sz_ra;
    logic               ord_we;
    logic [JOB_W-1:0]   ord_wa, ord_wd, ord_ra;
    logic               tot_we;
    logic [GRP_W-1:0]   tot_wa, tot_ra;
    logic [TOTAL_W-1:0] tot_wd;
    logic               res_load;
    logic               res_last;

    always_ff @(posedge i_clk) begin
        if (sz_we) begin
            size_mem[r_cnt[JOB_W-1:0]] <= i_job.payload.job_size;
        end
        r_sz_rd <= size_mem[sz_ra];
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        r_ord_rd <= order_mem[ord_ra];
        if (tot_we) begin
            tot_mem[tot_wa] <= tot_wd;
        end
        r_tot_rd <= tot_mem[tot_ra];
    end

    logic [GRP_W:0] g_eff;
    always_comb begin
        if (r_cfg == '0) begin
            g_eff = (GRP_W+1)'(1);
        end else if (r_cfg > CFG_W'(MAX_GROUPS)) begin
            g_eff = (GRP_W+1)'(MAX_GROUPS);
        end else begin
            g_eff = r_cfg;
        end
    end

    logic [TOTAL_W-1:0] sum;
    assign sum = r_bmin + TOTAL_W'(r_sz_rd);

    logic scan_take;
    assign scan_take = (r_k == (GRP_W+1)'(1)) || (r_tot_rd < r_bmin);

    assign res_last = ((r_i + CNT_W'(1)) == r_cnt);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_best = r_best;
        n_bmin = r_bmin;
        sz_we = 1'b0;
        sz_ra = r_id;
        ord_we = 1'b0;
        ord_wa = r_j[JOB_W-1:0];
        ord_wd = r_i[JOB_W-1:0];
        ord_ra = JOB_W'(r_j - CNT_W'(1));
        tot_we = 1'b0;
        tot_wa = r_k[GRP_W-1:0];
        tot_wd = '0;
        tot_ra = r_k[GRP_W-1:0];
        res_load = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (acc) begin
                    if (r_cnt < CNT_W'(MAX_JOBS)) begin
                        sz_we = 1'b1;
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_job.payload.is_last) begin
                        n_k = '0;
                        n_state = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                tot_we = 1'b1;
                n_k = r_k + (GRP_W+1)'(1);
                if (r_k == (GRP_W+1)'(MAX_GROUPS - 1)) begin
                    n_i = '0;
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                // fetch the key size of job r_i
                sz_ra = r_i[JOB_W-1:0];
                if (r_i == r_cnt) begin
                    n_i = '0;
                    n_state = ST_ASG_RD;
                end else begin
                    n_j = r_i;
                    n_state = ST_SORT_KEY;
                end
            end
            ST_SORT_KEY: begin
                if (r_j == '0) begin
                    n_state = ST_SORT_PUT;
                end else begin
                    n_state = ST_SORT_ORD;
                end
            end
            ST_SORT_ORD: begin
                // r_ord_rd holds order[j-1]; fetch its size
                sz_ra = r_ord_rd;
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (r_sz_rd < r_key) begin
                    // shift right and continue left
                    ord_we = 1'b1;
                    ord_wd = r_ord_rd;
                    n_j = r_j - CNT_W'(1);
                    ord_ra = JOB_W'(r_j - CNT_W'(2));
                    if (r_j == CNT_W'(1)) begin
                        n_state = ST_SORT_PUT;
                    end else begin
                        n_state = ST_SORT_ORD;
                    end
                end else begin
                    n_state = ST_SORT_PUT;
                end
            end
            ST_SORT_PUT: begin
                ord_we = 1'b1;
                n_i = r_i + CNT_W'(1);
                n_state = ST_SORT_RD;
            end
            ST_ASG_RD: begin
                ord_ra = r_i[JOB_W-1:0];
                n_state = ST_ASG_ID;
            end
            ST_ASG_ID: begin
                sz_ra = r_ord_rd;
                tot_ra = '0;
                n_k = (GRP_W+1)'(1);
                n_state = ST_ASG_SCAN;
            end
            ST_ASG_SCAN: begin
                // r_tot_rd is the total of group r_k-1
                if (scan_take) begin
                    n_best = GRP_W'(r_k - (GRP_W+1)'(1));
                    n_bmin = r_tot_rd;
                end
                if (r_k == r_g) begin
                    n_state = ST_ASG_ADD;
                end else begin
                    n_k = r_k + (GRP_W+1)'(1);
                end
            end
            ST_ASG_ADD: begin
                if (!r_ovalid || o_res.ready) begin
                    tot_we = 1'b1;
                    tot_wa = r_best;
                    tot_wd = sum;
                    res_load = 1'b1;
                    n_i = r_i + CNT_W'(1);
                    if (res_last) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_ASG_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cfg    <= CFG_W'(1);
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_g      <= (GRP_W+1)'(1);
            r_best   <= '0;
            r_bmin   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_best  <= n_best;
            r_bmin  <= n_bmin;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // take the group count present at the last item
            if (acc && i_job.payload.is_last) begin
                r_g <= g_eff;
            end
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (r_state == ST_SORT_KEY) begin
            r_key <= r_sz_rd;
        end
        if (r_state == ST_ASG_ID) begin
            r_id <= r_ord_rd;
        end
        if (res_load) begin
            r_res.job_id      <= r_id;
            r_res.group_index <= r_best;
            r_res.group_total <= sum;
            r_res.overflow    <= r_ovf;
            r_res.last_result <= res_last;
        end
    end

    `LPT_ASSERT_IMPL(a_no_ready_busy, r_state != ST_LOAD, !i_job.ready,
        "input ready outside load")
    `LPT_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_JOBS), "job count above capacity")
    `LPT_ASSERT_NEXT(a_res_hold, o_res.valid && !o_res.ready, o_res.valid,
        "result dropped while stalled")
    `LPT_ASSERT_NEXT(a_res_stable, o_res.valid && !o_res.ready, $stable(o_res.payload),
        "result changed while stalled")
endmodule

### tb/sv/lpt_tb_if.sv
// Testbench package: idle modes of the sender and the receiver
`timescale 1ns / 100ps
package lpt_tb_pkg;
    import lpt_pkg::*;
    typedef enum int {IDLE_SRC_LOW, IDLE_SRC_HIGH, IDLE_NONE} t_idle_mode;
endpackage

### tb/sv/testbench.sv
// Self-checking testbench for the LPT greedy group balancer core
`timescale 1ns / 100ps
module testbench
    import lpt_pkg::*, lpt_tb_pkg::*;
();

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    lpt_job_if    job_ch ();
    lpt_result_if res_ch ();

    lpt_greedy_group_balancer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_job      (job_ch.sink),
        .o_res      (res_ch.source)
    );

    // predictor state
    logic [SIZE_W-1:0]  pend_sizes[$];
    logic               pend_ovf;
    logic [CFG_W-1:0]   groups_reg;
    t_result            expected_q[$];
    int                 fail_count;
    t_idle_mode         idle_mode;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("lpt_greedy_group_balancer_core test failed");
        $finish;
    end

    // Apply one accepted job to the predictor.
    task automatic predict_job(input logic [SIZE_W-1:0] sz, input logic last);
        int order[$];
        logic [TOTAL_W-1:0] totals[MAX_GROUPS];
        int g, n, j, best;
        t_result r;
        if (pend_sizes.size() < MAX_JOBS) pend_sizes = {pend_sizes, sz};
        else pend_ovf = 1'b1;
        if (!last) return;
        g = (groups_reg == 0) ? 1 : (groups_reg > MAX_GROUPS ? MAX_GROUPS : groups_reg);
        n = pend_sizes.size();
        for (int i = 0; i < MAX_GROUPS; i++) totals[i] = '0;
        // stable insertion sort, largest first
        for (int i = 0; i < n; i++) begin
            j = order.size();
            while (j > 0 && pend_sizes[order[j-1]] < pend_sizes[i]) j--;
            order.insert(j, i);
        end
        for (int i = 0; i < n; i++) begin
            best = 0;
            for (int k = 1; k < g; k++) if (totals[k] < totals[best]) best = k;
            totals[best] = totals[best] + TOTAL_W'(pend_sizes[order[i]]);
            r.job_id      = JOB_W'(order[i]);
            r.group_index = GRP_W'(best);
            r.group_total = totals[best];
            r.overflow    = pend_ovf;
            r.last_result = (i == n - 1);
            expected_q = {expected_q, r};
        end
        pend_sizes.delete();
        pend_ovf = 1'b0;
    endtask

    task automatic send_job(input logic [SIZE_W-1:0] sz, input logic last);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SRC_LOW) ? 17 : ((idle_mode == IDLE_SRC_HIGH) ? 50 : 0);
        while ($urandom_range(99) < idle_pct) begin
            job_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        job_ch.valid <= 1'b1;
        job_ch.payload <= '{job_size: sz, is_last: last};
        do @(posedge i_clk); while (!job_ch.ready);
        predict_job(sz, last);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        job_ch.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_groups(input logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        groups_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(3))
            0: rand_size = SIZE_W'($urandom_range(7));
            1: rand_size = SIZE_W'({$urandom, $urandom});
            2: rand_size = {SIZE_W{1'b1}} - SIZE_W'($urandom_range(3));
            default: rand_size = SIZE_W'($urandom_range(4095));
        endcase
    endfunction

    // check results
    always @(posedge i_clk) begin
        t_result e, a;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            a = res_ch.payload;
            if (expected_q.size() == 0) begin
                $error("unexpected result job_id=%0d", a.job_id);
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (a.job_id !== e.job_id) begin
                    $error("job_id exp %0d got %0d", e.job_id, a.job_id); fail_count++;
                end
                if (a.group_index !== e.group_index) begin
                    $error("group_index exp %0d got %0d", e.group_index, a.group_index);
                    fail_count++;
                end
                if (a.group_total !== e.group_total) begin
                    $error("group_total exp %0d got %0d", e.group_total, a.group_total);
                    fail_count++;
                end
                if (a.overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, a.overflow); fail_count++;
                end
                if (a.last_result !== e.last_result) begin
                    $error("last_result exp %0d got %0d", e.last_result, a.last_result);
                    fail_count++;
                end
            end
        end
    end

    // drive receiver ready
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_SRC_LOW) res_ch.ready <= ($urandom_range(99) >= 50);
        else if (idle_mode == IDLE_SRC_HIGH) res_ch.ready <= ($urandom_range(99) >= 17);
        else res_ch.ready <= 1'b1;
    end

    task automatic test_extremes();
        write_groups(5'd3);
        send_job('0, 1'b0);
        send_job({SIZE_W{1'b1}}, 1'b0);
        send_job(40'd5, 1'b0);
        send_job(40'd5, 1'b0);
        send_job({SIZE_W{1'b1}}, 1'b1);
        send_job(40'h55_5555_5555, 1'b1);
        send_job(40'hAA_AAAA_AAAA, 1'b1);
    endtask

    task automatic test_group_limits();
        write_groups(5'd0);
        for (int i = 0; i < 4; i++) send_job(SIZE_W'(i * 7), i == 3);
        write_groups(5'd16);
        for (int i = 0; i < 20; i++) send_job(rand_size(), i == 19);
        write_groups(5'd31);
        for (int i = 0; i < 18; i++) send_job(rand_size(), i == 17);
    endtask

    task automatic test_overflow();
        write_groups(5'd5);
        for (int i = 0; i < 66; i++) send_job(rand_size(), i == 65);
        // after overflow flag clears
        send_job(40'd9, 1'b1);
    endtask

    task automatic test_cfg_midload();
        write_groups(5'd2);
        send_job(40'd100, 1'b0);
        send_job(40'd50, 1'b0);
        drain_results();
        i_cfg_we <= 1'b1; i_cfg_data <= 5'd4; groups_reg = 5'd4;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_job(40'd25, 1'b1);
    endtask

    task automatic test_random(input int items);
        int sent, len;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) write_groups(CFG_W'($urandom_range(31)));
            len = ($urandom_range(15) == 0) ? $urandom_range(70, 60) : $urandom_range(12, 1);
            for (int i = 0; i < len; i++) send_job(rand_size(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        fail_count = 0;
        idle_mode = IDLE_SRC_LOW;
        groups_reg = 5'd1;
        pend_ovf = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        job_ch.valid = 1'b0;
        job_ch.payload = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_group_limits();
        test_overflow();
        test_cfg_midload();
        test_random(95);
        // hold until all results arrive
        drain_results();
        idle_mode = IDLE_SRC_HIGH;
        test_random(95);
        idle_mode = IDLE_NONE;
        test_random(95);
        drain_results();
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("lpt_greedy_group_balancer_core test passed");
        end else begin
            if (expected_q.size() != 0) $error("%0d results missing", expected_q.size());
            $display("lpt_greedy_group_balancer_core test failed");
        end
        $finish;
    end
endmodule
